FILE: design/sbrpm_pkg.sv
// shared types and constants of the stereo block rms and peak meter
// no dependencies; used by the controller, the datapath and the top level
`default_nettype none

package sbrpm_pkg;

    localparam int SAMPLE_W = 16;                  // q1.15 sample and result width
    localparam int SQUARE_W = 2 * SAMPLE_W;        // width of one squared magnitude
    localparam int SUM_W = 44;                     // square sum accumulator width
    localparam int ROOT_W = SUM_W / 2;             // integer square root width
    localparam int STEP_W = $clog2(SUM_W + 1);     // iteration counter width

    localparam int DEFAULT_MAX_BLOCK_FRAMES = 8192;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 16'h8000;
    localparam logic [SAMPLE_W-1:0] CLIP_LEVEL_RESET = FULL_SCALE;

    // controller states
    typedef enum logic [3:0] {
        ST_ACCUM   = 4'b0001,
        ST_DIVIDE  = 4'b0010,
        ST_ROOT    = 4'b0100,
        ST_DELIVER = 4'b1000
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic accum;       // accumulate the accepted frame
        logic div_step;    // one restoring divide step on both channels
        logic root_step;   // one square root digit on both channels
        logic out_load;    // move the block result into the output register
    } cmd_t;

endpackage

`default_nettype wire

FILE: design/sbrpm_ctrl.sv
// controller of the stereo block meter: sequences accumulate, divide, root, deliver
// depends on sbrpm_pkg
`default_nettype none

module sbrpm_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    input  wire logic          s_last_of_block,
    output logic               s_ready,
    output logic               m_valid,
    input  wire logic          m_ready,
    output sbrpm_pkg::cmd_t    cmd
);

    localparam int STEP_W = sbrpm_pkg::STEP_W;
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(sbrpm_pkg::SUM_W - 1);
    localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(sbrpm_pkg::ROOT_W - 1);

    sbrpm_pkg::state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;
    logic              accept;

    assign s_ready = (state_reg == sbrpm_pkg::ST_ACCUM);
    assign m_valid = m_valid_reg;
    assign accept  = s_valid && s_ready;

    always_comb begin
        cmd.accum     = accept;
        cmd.div_step  = (state_reg == sbrpm_pkg::ST_DIVIDE);
        cmd.root_step = (state_reg == sbrpm_pkg::ST_ROOT);
        cmd.out_load  = (state_reg == sbrpm_pkg::ST_DELIVER) && (!m_valid_reg || m_ready);
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            sbrpm_pkg::ST_ACCUM: begin
                if (accept && s_last_of_block) begin
                    state_next = sbrpm_pkg::ST_DIVIDE;
                    step_next  = '0;
                end
            end
            sbrpm_pkg::ST_DIVIDE: begin
                if (step_reg == DIV_LAST) begin
                    state_next = sbrpm_pkg::ST_ROOT;
                    step_next  = '0;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            sbrpm_pkg::ST_ROOT: begin
                if (step_reg == ROOT_LAST) begin
                    state_next = sbrpm_pkg::ST_DELIVER;
                    step_next  = '0;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            sbrpm_pkg::ST_DELIVER: begin
                if (cmd.out_load) begin
                    state_next = sbrpm_pkg::ST_ACCUM;
                end
            end
            default: begin
                state_next = sbrpm_pkg::ST_ACCUM;
                step_next  = '0;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sbrpm_pkg::ST_ACCUM;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // a block end always starts the divide
    a_last_starts_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_of_block |=> state_reg == sbrpm_pkg::ST_DIVIDE)
        else $error("block end did not start the divide");

    // the root phase runs exactly its digit count, then delivers
    a_root_to_deliver: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sbrpm_pkg::ST_ROOT && step_reg == ROOT_LAST
        |=> state_reg == sbrpm_pkg::ST_DELIVER)
        else $error("root phase did not end in deliver");

    // a result appears only out of the deliver state
    a_result_from_deliver: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == sbrpm_pkg::ST_DELIVER))
        else $error("result raised outside deliver");

    // the divide counter never runs past the dividend width
    a_divide_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sbrpm_pkg::ST_DIVIDE |-> step_reg <= DIV_LAST)
        else $error("divide counter out of range");

endmodule

`default_nettype wire

FILE: design/sbrpm_datapath.sv
// datapath of the stereo block meter: accumulators, serial divider, serial root, result register
// depends on sbrpm_pkg; driven by sbrpm_ctrl commands
`default_nettype none

module sbrpm_datapath #(
    parameter int MAX_BLOCK_FRAMES = sbrpm_pkg::DEFAULT_MAX_BLOCK_FRAMES
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire sbrpm_pkg::cmd_t                       cmd,
    input  wire logic                                  cfg_we,
    input  wire logic        [sbrpm_pkg::SAMPLE_W-1:0] cfg_wdata,
    input  wire logic signed [sbrpm_pkg::SAMPLE_W-1:0] s_left_sample,
    input  wire logic signed [sbrpm_pkg::SAMPLE_W-1:0] s_right_sample,
    input  wire logic                                  s_last_of_block,
    output logic             [sbrpm_pkg::SAMPLE_W-1:0] m_rms_left,
    output logic             [sbrpm_pkg::SAMPLE_W-1:0] m_rms_right,
    output logic             [sbrpm_pkg::SAMPLE_W-1:0] m_left_peak,
    output logic             [sbrpm_pkg::SAMPLE_W-1:0] m_right_peak,
    output logic                                       m_left_clipped,
    output logic                                       m_right_clipped
);

    localparam int SAMPLE_W = sbrpm_pkg::SAMPLE_W;
    localparam int SQUARE_W = sbrpm_pkg::SQUARE_W;
    localparam int SUM_W    = sbrpm_pkg::SUM_W;
    localparam int ROOT_W   = sbrpm_pkg::ROOT_W;
    localparam int COUNT_W  = $clog2(MAX_BLOCK_FRAMES + 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_BLOCK_FRAMES);

    logic [SAMPLE_W-1:0] thresh_reg;
    logic [COUNT_W-1:0]  count_reg, count_new;
    logic [COUNT_W-1:0]  divisor_reg;
    logic                block_end;

    // channel 0 is left, channel 1 is right
    logic [SAMPLE_W-1:0] raw       [2];
    logic [SAMPLE_W-1:0] out_rms   [2];
    logic [SAMPLE_W-1:0] out_peak  [2];
    logic                out_clip  [2];

    assign raw[0]    = s_left_sample;
    assign raw[1]    = s_right_sample;
    assign block_end = cmd.accum && s_last_of_block;

    assign count_new = (count_reg < COUNT_MAX) ? count_reg + 1'b1 : count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= sbrpm_pkg::CLIP_LEVEL_RESET;
            count_reg  <= '0;
        end else begin
            if (cfg_we) begin
                thresh_reg <= cfg_wdata;
            end
            if (block_end) begin
                count_reg <= '0;
            end else if (cmd.accum) begin
                count_reg <= count_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (block_end) begin
            divisor_reg <= count_new;
        end
    end

    for (genvar c = 0; c < 2; c++) begin : g_chan
        logic [SAMPLE_W-1:0] mag;
        logic [SQUARE_W-1:0] square;
        logic [SUM_W:0]      sum_wide;
        logic [SUM_W-1:0]    sum_new;
        logic [SAMPLE_W-1:0] peak_new;
        logic [SUM_W-1:0]    sum_reg;
        logic [SAMPLE_W-1:0] peak_reg;

        // quotient register doubles as the root radicand
        logic [SUM_W-1:0]    quo_reg;
        logic [COUNT_W-1:0]  rem_reg;
        logic [COUNT_W:0]    rem_shift;
        logic                rem_ge;

        logic [ROOT_W-1:0]   srem_reg;
        logic [ROOT_W-1:0]   root_reg;
        logic [ROOT_W+1:0]   srem_shift;
        logic [ROOT_W+1:0]   trial;
        logic [ROOT_W+1:0]   srem_sub;
        logic                srem_ge;

        logic [SAMPLE_W-1:0] hold_peak_reg;
        logic                hold_clip_reg;
        logic [SAMPLE_W-1:0] rms_reg;
        logic [SAMPLE_W-1:0] peak_out_reg;
        logic                clip_out_reg;

        // most negative sample maps to full scale
        assign mag      = raw[c][SAMPLE_W-1] ? (~raw[c] + 1'b1) : raw[c];
        assign square   = mag * mag;
        assign sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(square);
        assign sum_new  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        assign peak_new = (mag > peak_reg) ? mag : peak_reg;

        // restoring divide, one quotient bit per step
        assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
        assign rem_ge    = (rem_shift >= {1'b0, divisor_reg});

        // digit-by-digit root, two radicand bits per step
        assign srem_shift = {srem_reg, quo_reg[SUM_W-1 -: 2]};
        assign trial      = {root_reg, 2'b01};
        assign srem_ge    = (srem_shift >= trial);
        assign srem_sub   = srem_shift - trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sum_reg  <= '0;
                peak_reg <= '0;
            end else if (block_end) begin
                sum_reg  <= '0;
                peak_reg <= '0;
            end else if (cmd.accum) begin
                sum_reg  <= sum_new;
                peak_reg <= peak_new;
            end
        end

        always_ff @(posedge aclk) begin
            if (block_end) begin
                quo_reg       <= sum_new;
                rem_reg       <= '0;
                srem_reg      <= '0;
                root_reg      <= '0;
                hold_peak_reg <= peak_new;
                hold_clip_reg <= (peak_new >= thresh_reg);
            end else if (cmd.div_step) begin
                quo_reg <= {quo_reg[SUM_W-2:0], rem_ge};
                rem_reg <= rem_ge ? COUNT_W'(rem_shift - {1'b0, divisor_reg})
                                  : rem_shift[COUNT_W-1:0];
            end else if (cmd.root_step) begin
                quo_reg  <= {quo_reg[SUM_W-3:0], 2'b00};
                srem_reg <= srem_ge ? srem_sub[ROOT_W-1:0] : srem_shift[ROOT_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], srem_ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (cmd.out_load) begin
                rms_reg      <= (root_reg > ROOT_W'(sbrpm_pkg::FULL_SCALE))
                                ? sbrpm_pkg::FULL_SCALE : root_reg[SAMPLE_W-1:0];
                peak_out_reg <= hold_peak_reg;
                clip_out_reg <= hold_clip_reg;
            end
        end

        assign out_rms[c]  = rms_reg;
        assign out_peak[c] = peak_out_reg;
        assign out_clip[c] = clip_out_reg;
    end

    assign m_rms_left      = out_rms[0];
    assign m_rms_right     = out_rms[1];
    assign m_left_peak     = out_peak[0];
    assign m_right_peak    = out_peak[1];
    assign m_left_clipped  = out_clip[0];
    assign m_right_clipped = out_clip[1];

endmodule

`default_nettype wire

FILE: design/stereo_block_rms_peak_meter.sv
// top level of the stereo block rms and peak meter
// depends on sbrpm_pkg, sbrpm_ctrl and sbrpm_datapath
`default_nettype none

// Stereo block meter. Each request on the s_ channel is one stereo frame of
// signed Q1.15 samples; s_last_of_block closes an analysis block. Per channel
// the block sums squared magnitudes (44 bits, saturating) and tracks the peak
// magnitude, with -32768 counted as 32768. Ordinary frames are taken at one per
// clock. The frame that closes a block is accumulated too, then the meter stops
// taking frames while a serial divider finds floor(sum / frames) (one quotient
// bit per cycle) and a serial square root takes that quotient apart two bits
// at a time; then the output register is loaded. m_valid rises with that load,
// s_ready is low from the closing frame until it, and the next frame is also
// held off while the previous result still waits on m_ready. The result request
// carries rms (clamped at full scale 32768), peak and a clip flag per channel,
// set when the peak is at or above the clip level. The frame count stops at
// MAX_BLOCK_FRAMES; frames beyond it still feed the sums and peaks. The clip
// level resets to 32768 and is written through cfg_we / cfg_wdata; the user must
// write it only while the meter is idle, which the block itself does not
// enforce.

module stereo_block_rms_peak_meter #(
    parameter int MAX_BLOCK_FRAMES = sbrpm_pkg::DEFAULT_MAX_BLOCK_FRAMES
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,

    // configuration: clip level
    input  wire logic                                  cfg_we,
    input  wire logic        [sbrpm_pkg::SAMPLE_W-1:0] cfg_wdata,

    // frame requests
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic signed [sbrpm_pkg::SAMPLE_W-1:0] s_left_sample,
    input  wire logic signed [sbrpm_pkg::SAMPLE_W-1:0] s_right_sample,
    input  wire logic                                  s_last_of_block,

    // block result requests
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic             [sbrpm_pkg::SAMPLE_W-1:0] m_rms_left,
    output logic             [sbrpm_pkg::SAMPLE_W-1:0] m_rms_right,
    output logic             [sbrpm_pkg::SAMPLE_W-1:0] m_left_peak,
    output logic             [sbrpm_pkg::SAMPLE_W-1:0] m_right_peak,
    output logic                                       m_left_clipped,
    output logic                                       m_right_clipped
);

    // command bundle from sequencer to datapath
    sbrpm_pkg::cmd_t cmd;

    // sequencer: frame handshake, divide and root phases, result handshake
    sbrpm_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_last_of_block (s_last_of_block),
        .s_ready         (s_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .cmd             (cmd)
    );

    // accumulators, serial divider and root per channel, result register
    sbrpm_datapath #(
        .MAX_BLOCK_FRAMES (MAX_BLOCK_FRAMES)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_left_sample   (s_left_sample),
        .s_right_sample  (s_right_sample),
        .s_last_of_block (s_last_of_block),
        .m_rms_left      (m_rms_left),
        .m_rms_right     (m_rms_right),
        .m_left_peak     (m_left_peak),
        .m_right_peak    (m_right_peak),
        .m_left_clipped  (m_left_clipped),
        .m_right_clipped (m_right_clipped)
    );

endmodule

`default_nettype wire

FILE: tb/sv/stereo_block_rms_peak_meter_test.sv
// self-checking testbench for the stereo block rms and peak meter, bit-exact block predictor
// depends on sbrpm_pkg and stereo_block_rms_peak_meter
`timescale 1ns / 1ps

module stereo_block_rms_peak_meter_test;

    localparam int SAMPLE_W = sbrpm_pkg::SAMPLE_W;
    localparam int SQUARE_W = sbrpm_pkg::SQUARE_W;
    localparam int SUM_W = sbrpm_pkg::SUM_W;
    localparam int ROOT_W = sbrpm_pkg::ROOT_W;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE = sbrpm_pkg::FULL_SCALE;
    localparam logic [SAMPLE_W-1:0] CLIP_LEVEL_RESET = sbrpm_pkg::CLIP_LEVEL_RESET;

    localparam int FRAME_COUNT_LIMIT = sbrpm_pkg::DEFAULT_MAX_BLOCK_FRAMES;
    localparam logic [SUM_W-1:0] SUM_CEILING = {SUM_W{1'b1}};
    localparam int SETTLE_CYCLES = 100;   // covers divide + root + load of one block end
    localparam int STALL_LIMIT = 5000;    // cycles without any accepted request

    // one stereo frame request
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       last_of_block;
    } frame_t;

    // one block result request
    typedef struct packed {
        logic [SAMPLE_W-1:0] rms_left;
        logic [SAMPLE_W-1:0] rms_right;
        logic [SAMPLE_W-1:0] left_peak;
        logic [SAMPLE_W-1:0] right_peak;
        logic                left_clipped;
        logic                right_clipped;
    } block_report_t;

    // clock, reset and block inputs, all known from time zero
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [SAMPLE_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [SAMPLE_W-1:0] s_left_sample = '0;
    logic signed [SAMPLE_W-1:0] s_right_sample = '0;
    logic s_last_of_block = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [SAMPLE_W-1:0] m_rms_left;
    logic [SAMPLE_W-1:0] m_rms_right;
    logic [SAMPLE_W-1:0] m_left_peak;
    logic [SAMPLE_W-1:0] m_right_peak;
    logic m_left_clipped;
    logic m_right_clipped;

    // stimulus and expectation stores
    frame_t frames_to_send[$];
    block_report_t reports_due[$];

    // predictor copy of the meter state and the clip level
    logic [SUM_W-1:0] left_sum_acc;
    logic [SUM_W-1:0] right_sum_acc;
    logic [SAMPLE_W-1:0] left_peak_acc;
    logic [SAMPLE_W-1:0] right_peak_acc;
    int unsigned frames_acc;
    logic [SAMPLE_W-1:0] clip_level;

    // driver and monitor bookkeeping
    logic frame_taken = 1'b0;
    bit idling_on = 1'b1;
    int s_gap = 0;
    int m_gap = 0;
    int quiet_cycles = 0;
    int mismatches = 0;

    stereo_block_rms_peak_meter #(
        .MAX_BLOCK_FRAMES(FRAME_COUNT_LIMIT)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_left_sample  (s_left_sample),
        .s_right_sample (s_right_sample),
        .s_last_of_block(s_last_of_block),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_rms_left     (m_rms_left),
        .m_rms_right    (m_rms_right),
        .m_left_peak    (m_left_peak),
        .m_right_peak   (m_right_peak),
        .m_left_clipped (m_left_clipped),
        .m_right_clipped(m_right_clipped)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    // two's complement magnitude, -32768 maps to 32768
    function automatic logic [SAMPLE_W-1:0] magnitude(input logic [SAMPLE_W-1:0] s);
        return s[SAMPLE_W-1] ? (~s + 1'b1) : s;
    endfunction

    // add one squared magnitude, pinned at the 44 bit ceiling
    function automatic logic [SUM_W-1:0] add_square(input logic [SUM_W-1:0] sum,
                                                    input logic [SAMPLE_W-1:0] mag);
        logic [SQUARE_W-1:0] sq;
        logic [SUM_W:0] total;
        sq = SQUARE_W'(mag) * SQUARE_W'(mag);
        total = (SUM_W + 1)'(sum) + (SUM_W + 1)'(sq);
        return total[SUM_W] ? SUM_CEILING : total[SUM_W-1:0];
    endfunction

    // integer square root by trial bits from the top, clamped at full scale
    function automatic logic [SAMPLE_W-1:0] root_clamped(input logic [SUM_W-1:0] quotient);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= 64'(quotient))
                root = trial;
        end
        return (root > 64'(FULL_SCALE)) ? FULL_SCALE : root[SAMPLE_W-1:0];
    endfunction

    // accumulate one frame; on a block end fill in the report and clear the block
    function automatic bit meter_frame(input frame_t f, output block_report_t rpt);
        logic [SAMPLE_W-1:0] lmag;
        logic [SAMPLE_W-1:0] rmag;
        lmag = magnitude(f.left);
        rmag = magnitude(f.right);
        left_sum_acc = add_square(left_sum_acc, lmag);
        right_sum_acc = add_square(right_sum_acc, rmag);
        if (lmag > left_peak_acc)
            left_peak_acc = lmag;
        if (rmag > right_peak_acc)
            right_peak_acc = rmag;
        if (frames_acc < FRAME_COUNT_LIMIT)
            frames_acc++;
        rpt = '0;
        if (!f.last_of_block)
            return 1'b0;
        rpt.rms_left = root_clamped(left_sum_acc / SUM_W'(frames_acc));
        rpt.rms_right = root_clamped(right_sum_acc / SUM_W'(frames_acc));
        rpt.left_peak = left_peak_acc;
        rpt.right_peak = right_peak_acc;
        rpt.left_clipped = (left_peak_acc >= clip_level);
        rpt.right_clipped = (right_peak_acc >= clip_level);
        left_sum_acc = '0;
        right_sum_acc = '0;
        left_peak_acc = '0;
        right_peak_acc = '0;
        frames_acc = 0;
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // ---------------------------------------------------------------- driver

    // frame requests change at the falling edge; a request stays put until taken
    always @(negedge aclk) begin
        frame_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || frame_taken) begin
            if (s_gap > 0) begin
                s_valid <= 1'b0;
                s_gap--;
            end else if (frames_to_send.size() == 0) begin
                s_valid <= 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                // idle burst, its length drawn at random into s_gap
                s_valid <= 1'b0;
                s_gap = $urandom_range(0, 4);
            end else begin
                nxt = frames_to_send.pop_front();
                s_valid <= 1'b1;
                s_left_sample <= nxt.left;
                s_right_sample <= nxt.right;
                s_last_of_block <= nxt.last_of_block;
            end
        end
    end

    // result side back-pressure in bursts of random length
    always @(negedge aclk) begin
        if (m_gap > 0) begin
            m_ready <= 1'b0;
            m_gap--;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            m_gap = $urandom_range(0, 4);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- monitor

    // everything sampled at the rising edge, where the handshakes complete
    always @(posedge aclk) begin
        frame_t taken;
        block_report_t due;
        block_report_t seen;
        if (!aresetn) begin
            frame_taken <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            frame_taken <= s_valid && s_ready;
            if (cfg_we)
                clip_level = cfg_wdata;
            // predict on every accepted frame request
            if (s_valid && s_ready) begin
                taken.left = s_left_sample;
                taken.right = s_right_sample;
                taken.last_of_block = s_last_of_block;
                if (meter_frame(taken, due))
                    reports_due.push_back(due);
            end
            // compare every accepted result request with the oldest prediction
            if (m_valid && m_ready) begin
                seen.rms_left = m_rms_left;
                seen.rms_right = m_rms_right;
                seen.left_peak = m_left_peak;
                seen.right_peak = m_right_peak;
                seen.left_clipped = m_left_clipped;
                seen.right_clipped = m_right_clipped;
                if (reports_due.size() == 0) begin
                    $error("result request with no block end pending");
                    mismatches++;
                end else begin
                    due = reports_due.pop_front();
                    check_field("rms_left", due.rms_left, seen.rms_left);
                    check_field("rms_right", due.rms_right, seen.rms_right);
                    check_field("left_peak", due.left_peak, seen.left_peak);
                    check_field("right_peak", due.right_peak, seen.right_peak);
                    check_field("left_clipped", due.left_clipped, seen.left_clipped);
                    check_field("right_clipped", due.right_clipped, seen.right_clipped);
                end
            end
            // watchdog count of cycles with no request moving on either side
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus

    function automatic void queue_frame(input logic [SAMPLE_W-1:0] l,
                                        input logic [SAMPLE_W-1:0] r, input logic last);
        frame_t f;
        f.left = l;
        f.right = r;
        f.last_of_block = last;
        frames_to_send.push_back(f);
    endfunction

    // mix of edge values and random samples, shift scales the block loudness down
    function automatic logic [SAMPLE_W-1:0] pick_sample(input int shift);
        logic signed [SAMPLE_W-1:0] raw;
        raw = 16'($urandom);
        case ($urandom_range(0, 11))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'h0001;
            default: return raw >>> shift;
        endcase
    endfunction

    // whole blocks with random lengths, mostly short, until about n frames are queued
    function automatic void queue_random_blocks(input int n);
        int queued;
        int len;
        int shift;
        queued = 0;
        while (queued < n) begin
            case ($urandom_range(0, 19))
                0: len = $urandom_range(41, 100);
                1, 2, 3: len = $urandom_range(13, 40);
                default: len = $urandom_range(1, 12);
            endcase
            shift = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 0;
            for (int i = 0; i < len; i++)
                queue_frame(pick_sample(shift), pick_sample(shift), i == len - 1);
            queued += len;
        end
    endfunction

    // block idle: nothing queued, nothing on the bus, no result pending
    task automatic wait_drained();
        do begin
            @(posedge aclk);
            #1;
        end while (frames_to_send.size() != 0 || s_valid || reports_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_clip_level(input logic [SAMPLE_W-1:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        left_sum_acc = '0;
        right_sum_acc = '0;
        left_peak_acc = '0;
        right_peak_acc = '0;
        frames_acc = 0;
        clip_level = CLIP_LEVEL_RESET;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // clip level at its reset value: extremes and single-frame blocks
        queue_frame(16'h0000, 16'h0000, 1'b1);
        queue_frame(16'h8000, 16'h7FFF, 1'b1);
        queue_frame(16'h7FFF, 16'h8000, 1'b0);
        queue_frame(16'h0001, 16'hFFFF, 1'b0);
        queue_frame(16'hFFFF, 16'h0001, 1'b0);
        queue_frame(16'h0000, 16'h0000, 1'b1);
        queue_frame(16'h8000, 16'h8000, 1'b0);
        queue_frame(16'h8000, 16'h8000, 1'b1);
        queue_frame(16'h7FFF, 16'h0001, 1'b1);
        // accumulators must come back cleared
        queue_frame(16'd5, -16'sd5, 1'b1);
        queue_random_blocks(150);

        // level zero flags every block, silent ones too
        write_clip_level(16'd0);
        queue_frame(16'h0000, 16'h0000, 1'b1);
        queue_frame(16'h0001, 16'h0000, 1'b1);
        queue_random_blocks(150);

        write_clip_level(FULL_SCALE);
        queue_frame(16'h8000, 16'h7FFF, 1'b1);
        queue_random_blocks(150);

        // lowest nonzero level: only silence escapes the flag
        write_clip_level(16'd1);
        queue_frame(16'h0000, 16'h0001, 1'b1);
        queue_frame(16'hFFFF, 16'h0000, 1'b1);
        queue_random_blocks(150);

        write_clip_level(16'($urandom_range(0, 32768)));
        queue_random_blocks(150);

        // last stretch runs with no idling on either side
        write_clip_level(16'h7FFF);
        wait_drained();
        idling_on = 1'b0;
        queue_frame(16'h7FFF, 16'h7FFE, 1'b1);
        queue_random_blocks(150);

        wait_drained();
        if (mismatches == 0 && reports_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
